// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define AST_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
// Checked at every clock edge, reset included.
`define AST_ANY(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define AST_CLK(label, prop)
`define AST_ANY(label, prop)
`endif
`endif

// ===== sv/si2dec_pkg.sv =====
// Types and constants for the signed integer to decimal ASCII converter.
package si2dec_pkg;

	localparam int MagW      = 32;
	localparam int NumDigits = 10;
	localparam int BcdW      = 4 * NumDigits;
	localparam int CntW      = 6;
	localparam int LeftW     = 4;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic shift;
	} bcd_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bcd_stat_t;

endpackage

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
//  channel | signals                          | dir | content
//  --------+----------------------------------+-----+------------------------------
//  input   | in_valid, in_ready, value        | in  | one signed 32-bit integer
//  output  | out_valid, out_ready, character, | out | one ASCII char per transfer,
//          | last                             |     | last marks the final char
//
// Steps: the input transfer, 32 double-dabble shifts and a done flag, one
// shift per leading zero digit dropped (up to 9, at least one digit stays),
// then one character per cycle when not stalled (sign first for negatives).
// One item in flight; in_ready is high only while idle.
// Reset clears the sequencer and the output valid; data registers are not reset.
// Output stalls hold the character register and freeze the digit shift-out.
`include "assert_macros.svh"
module signed_int_to_decimal_ascii_core
	import si2dec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [31:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        character,
	output logic              last
);

	state_t           state_q, state_d;
	logic [LeftW-1:0] left_q, left_d;     // digits still held in the BCD register
	logic             sign_q, sign_d;     // minus sign still to send
	bcd_cmd_t         cmd;
	bcd_stat_t        stat;
	logic [3:0]       top_digit;
	logic [MagW-1:0]  value_u;
	logic [MagW-1:0]  mag;

	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             load;
	logic [7:0]       char_d;
	logic             last_d;
	logic             out_free;

	// magnitude fits 32 unsigned bits, the most negative value included
	assign value_u = value;
	assign mag     = value_u[MagW-1] ? (~value_u + MagW'(1)) : value_u;

	si2dec_bcd u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mag       (mag),
		.stat      (stat),
		.top_digit (top_digit)
	);

	// output register frees when empty or being taken
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
			sign_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
			sign_q  <= sign_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		left_d    = left_q;
		sign_d    = sign_q;
		cmd.start = 1'b0;
		cmd.shift = 1'b0;
		in_ready  = 1'b0;
		load      = 1'b0;
		char_d    = CHAR_ZERO + {4'd0, top_digit};
		last_d    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					left_d    = LeftW'(NumDigits);
					sign_d    = value_u[MagW-1];
					state_d   = ST_CONV;
				end
			end
			ST_CONV: begin
				if (stat.done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (top_digit == 4'd0 && left_q > LeftW'(1)) begin
					cmd.shift = 1'b1;
					left_d    = left_q - LeftW'(1);
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					if (sign_q) begin
						char_d = CHAR_MINUS;
						sign_d = 1'b0;
					end else begin
						last_d    = (left_q == LeftW'(1));
						cmd.shift = 1'b1;
						left_d    = left_q - LeftW'(1);
						if (left_q == LeftW'(1)) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	`AST_CLK(a_done_in_conv, stat.done |-> (state_q == ST_CONV))
	`AST_CLK(a_emit_has_digits, (state_q == ST_EMIT) |-> (left_q != '0))
	`AST_CLK(a_accept_starts, (in_valid && in_ready) |=> (state_q == ST_CONV && stat.busy))
	`AST_CLK(a_last_is_digit, (out_valid && last) |-> (character - CHAR_ZERO < 8'd10))
	`AST_ANY(a_idle_no_work, (state_q == ST_IDLE) |-> (!stat.busy || !arst_n))

endmodule

// ===== sv/si2dec_bcd.sv =====
// Bit-serial binary to BCD converter with a digit shift-out port.
module si2dec_bcd
	import si2dec_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  bcd_cmd_t        cmd,
	input  logic [MagW-1:0] mag,
	output bcd_stat_t       stat,
	output logic [3:0]      top_digit
);

	logic [MagW-1:0] bin_q;
	logic [BcdW-1:0] bcd_q;
	logic [BcdW-1:0] adj;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	// add-3 on every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(MagW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[BcdW-2:0], bin_q[MagW-1]};
			bin_q <= {bin_q[MagW-2:0], 1'b0};
		end else if (cmd.shift) begin
			bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign top_digit = bcd_q[BcdW-1 -: 4];

endmodule

// ===== sim/tb_signed_int_to_decimal_ascii_core.sv =====
// Self-checking testbench for the signed integer to decimal ASCII converter.
module tb_signed_int_to_decimal_ascii_core
	import si2dec_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_VALUES = 340;  // on top of the directed values
	localparam int SETTLE_CYCLES = 60;   // idle margin after all text has drained
	localparam int MAX_REPORTS   = 10;

	// One character of expected text.
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} ascii_char_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic signed [31:0] value    = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        character;
	logic              last;

	ascii_char_t text_queue [$];  // predicted characters, oldest first
	int  bad_chars      = 0;
	int  checked_chars  = 0;
	int  values_sent    = 0;
	int  negatives_sent = 0;
	bit  no_idle        = 1'b0;   // disables idling on both sides

	signed_int_to_decimal_ascii_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Generous fixed time limit on the whole run.
	initial begin
		#5ms;
		$display("timeout with %0d characters still pending", text_queue.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Appends the decimal text of v to the queue. Magnitude is kept at 33 bits
	// so the most negative input negates without overflow.
	function automatic void predict_text(input logic signed [31:0] v);
		logic [32:0] mag;
		logic [7:0]  digits [$];
		mag = v[31] ? (~{1'b1, v} + 33'd1) : {1'b0, v};
		if (v[31])
			text_queue.push_back('{CHAR_MINUS, 1'b0});
		// zero still yields one digit
		do begin
			digits.push_front(CHAR_ZERO + 8'(mag % 33'd10));
			mag = mag / 33'd10;
		end while (mag != 0);
		foreach (digits[i])
			text_queue.push_back('{digits[i], 1'(i == digits.size() - 1)});
	endfunction

	// Receiver: ready is low with a chance of 23 in 100 unless idling is off.
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= 23);
	end

	// Checker: every output transfer against the oldest predicted character.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			checked_chars++;
			if (text_queue.size() == 0) begin
				bad_chars++;
				if (bad_chars <= MAX_REPORTS)
					$display("%0t: unexpected char 0x%02h last=%0b", $realtime,
						character, last);
			end else begin
				if (character !== text_queue[0].character ||
					last !== text_queue[0].last) begin
					bad_chars++;
					if (bad_chars <= MAX_REPORTS)
						$display("%0t: expected 0x%02h last=%0b, got 0x%02h last=%0b",
							$realtime, text_queue[0].character, text_queue[0].last,
							character, last);
				end
				void'(text_queue.pop_front());
			end
		end
	end

	// Sends one value. Valid stays high after the transfer so back-to-back
	// values never lower and raise it in one step; a gap lowers it first.
	task automatic send_value(input logic signed [31:0] v);
		int gap;
		gap = (!no_idle && $urandom_range(99) < 23) ? $urandom_range(1, 50) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		predict_text(v);
		values_sent++;
		if (v[31])
			negatives_sent++;
	endtask

	// Holds off the sender until every predicted character has come out.
	task automatic wait_for_text();
		in_valid <= 1'b0;
		while (text_queue.size() != 0) @(posedge clk);
	endtask

	// Zero, single digits, some decade edges, both 32-bit extremes,
	// alternating bit patterns.
	task automatic test_directed();
		logic signed [31:0] vals [] = '{
			32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
			32'sd99, -32'sd100, 32'sd12345, 32'sd2147483647, -32'sd2147483647,
			32'h8000_0000, 32'sd1000000000, -32'sd1000000000, 32'sd999999999,
			32'sd1999999999, 32'h5555_5555, 32'hAAAA_AAAA, 32'sd5
		};
		foreach (vals[i])
			send_value(vals[i]);
	endtask

	// Mix of full-range words (every bit toggles), values of a random digit
	// count, decade edges and small magnitudes; either sign.
	task automatic test_random();
		longint unsigned lo, hi, mag;
		int n;
		logic signed [31:0] v;
		for (int i = 0; i < RANDOM_VALUES; i++) begin
			// no idling at all for a stretch in the middle
			if (i == 120)
				no_idle <= 1'b1;
			if (i == 190)
				no_idle <= 1'b0;
			// sender pauses until all text has drained
			if (i == 230)
				wait_for_text();
			n  = $urandom_range(1, 10);
			lo = 1;
			repeat (n - 1) lo = lo * 10;
			hi = lo * 10 - 1;
			case ($urandom_range(3))
				0: mag = $urandom();
				1: mag = $urandom_range(32'(hi > 32'h7FFF_FFFF ? 32'h8000_0000 : hi),
					32'(n == 1 ? 0 : lo));
				2: mag = $urandom_range(1) ? lo : lo - 1;
				default: mag = $urandom_range(20);
			endcase
			v = 32'(mag);
			if ($urandom_range(1))
				v = -v;
			send_value(v);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();

		wait_for_text();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Converted %0d values (%0d negative), %0d characters checked.",
			values_sent, negatives_sent, checked_chars);
		$display("Covered zero, both 32-bit extremes, all digit counts and stalls.");
		if (bad_chars == 0 && text_queue.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d bad characters, %0d never arrived", bad_chars,
				text_queue.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/si2dec_pkg.sv
sv/si2dec_bcd.sv
sv/signed_int_to_decimal_ascii_core.sv
sim/tb_signed_int_to_decimal_ascii_core.sv
